// ===== design/mrwt_pkg.sv =====
// ============================================================================
// Miller-Rabin witness test package
// Widths, state encodings and the modular add shared by the witness test
// unit and its checker.
// ============================================================================
`default_nettype none

package mrwt_pkg;

    localparam int NUM_WIDTH   = 62;
    localparam int IN_W        = 62;
    localparam int CNT_W       = $clog2(NUM_WIDTH + 1);
    localparam int TDATA_IN_W  = ((2 * IN_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = 8;

    typedef logic [NUM_WIDTH-1:0] num_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_REDUCE = 8'b0000_0010,
        ST_SPLIT  = 8'b0000_0100,
        ST_POW    = 8'b0000_1000,
        ST_MUL    = 8'b0001_0000,
        ST_TEST   = 8'b0010_0000,
        ST_LOOP   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        MK_POW_ACC = 2'd0,
        MK_POW_SQ  = 2'd1,
        MK_LOOP    = 2'd2
    } mul_kind_t;

    // Sum of two residues below m, folded back below m.
    function automatic num_t add_mod(num_t x, num_t y, num_t m);
        logic [NUM_WIDTH:0] sum;
        begin
            sum = {1'b0, x} + {1'b0, y};
            if (sum >= {1'b0, m}) begin
                sum = sum - {1'b0, m};
            end
            return sum[NUM_WIDTH-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/miller_rabin_witness_test_unit.sv =====
// ============================================================================
// Miller-Rabin witness test unit
// One Miller-Rabin round for one odd candidate and one witness base, built
// around a single shift-and-add modular multiplier under a small sequencer.
// ============================================================================
// Each input word carries a candidate n and a witness base a; each output
// word carries the verdict for that base and a bad-input flag for a candidate
// that is even or below 3. The base is reduced modulo n one bit per cycle,
// n-1 is split into q times 2^r one bit per cycle, then a^q mod n is formed
// by square-and-multiply followed by up to r squarings. Every modular product
// runs on the one shift-and-add multiplier, which works through its second
// operand one bit at a time. The unit takes one word at a time; it accepts
// the next word as soon as a finished result sits in the output register.
`default_nettype none

module miller_rabin_witness_test_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: candidate[61:0], witness_base[123:62], zero fill.
    input  wire logic [mrwt_pkg::TDATA_IN_W-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Fields from bit 0: probably_prime[0], zero fill.
    output logic [mrwt_pkg::TDATA_OUT_W-1:0]      m_tdata,
    // Fields from bit 0: bad_input[0].
    output logic                                  m_tuser
);
    import mrwt_pkg::*;

    state_t    state_reg, state_next;
    mul_kind_t kind_reg, kind_next;
    num_t      n_reg, n_next;
    num_t      a_reg, a_next;
    num_t      e_reg, e_next;
    num_t      acc_reg, acc_next;
    num_t      sq_reg, sq_next;
    num_t      mul_acc_reg, mul_acc_next;
    num_t      mul_dbl_reg, mul_dbl_next;
    num_t      mul_y_reg, mul_y_next;
    cnt_t      cnt_reg, cnt_next;
    logic      pend_prime_reg, pend_prime_next;
    logic      pend_bad_reg, pend_bad_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_prime_reg, out_prime_next;
    logic      out_bad_reg, out_bad_next;

    num_t               cand_in;
    num_t               base_in;
    logic [NUM_WIDTH:0] rem_wide;
    logic [NUM_WIDTH:0] rem_sub;
    num_t               rem_step;
    num_t               acc_step;
    num_t               dbl_step;
    num_t               n_minus_1;

    assign cand_in   = s_tdata[NUM_WIDTH-1:0];
    assign base_in   = s_tdata[IN_W+NUM_WIDTH-1:IN_W];
    assign rem_wide  = {sq_reg, a_reg[NUM_WIDTH-1]};
    assign rem_sub   = rem_wide - {1'b0, n_reg};
    assign rem_step  = (rem_wide >= {1'b0, n_reg}) ? rem_sub[NUM_WIDTH-1:0]
                                                   : rem_wide[NUM_WIDTH-1:0];
    assign acc_step  = mul_y_reg[0] ? add_mod(mul_acc_reg, mul_dbl_reg, n_reg)
                                    : mul_acc_reg;
    assign dbl_step  = add_mod(mul_dbl_reg, mul_dbl_reg, n_reg);
    assign n_minus_1 = n_reg - NUM_WIDTH'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-1){1'b0}}, out_prime_reg};
    assign m_tuser  = out_bad_reg;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        n_next          = n_reg;
        a_next          = a_reg;
        e_next          = e_reg;
        acc_next        = acc_reg;
        sq_next         = sq_reg;
        mul_acc_next    = mul_acc_reg;
        mul_dbl_next    = mul_dbl_reg;
        mul_y_next      = mul_y_reg;
        cnt_next        = cnt_reg;
        pend_prime_next = pend_prime_reg;
        pend_bad_next   = pend_bad_reg;
        out_valid_next  = out_valid_reg;
        out_prime_next  = out_prime_reg;
        out_bad_next    = out_bad_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next   = cand_in;
                    a_next   = base_in;
                    e_next   = cand_in - NUM_WIDTH'(1);
                    sq_next  = '0;
                    cnt_next = CNT_W'(NUM_WIDTH - 1);
                    if ((cand_in < NUM_WIDTH'(3)) || !cand_in[0]) begin
                        pend_bad_next   = 1'b1;
                        pend_prime_next = 1'b0;
                        state_next      = ST_DONE;
                    end else begin
                        pend_bad_next = 1'b0;
                        state_next    = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                sq_next = rem_step;
                a_next  = a_reg << 1;
                if (cnt_reg == '0) begin
                    state_next = ST_SPLIT;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SPLIT: begin
                if (e_reg[0]) begin
                    acc_next   = NUM_WIDTH'(1);
                    state_next = ST_POW;
                end else begin
                    e_next   = e_reg >> 1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_POW: begin
                if (e_reg == '0) begin
                    state_next = ST_TEST;
                end else begin
                    mul_acc_next = '0;
                    mul_dbl_next = sq_reg;
                    state_next   = ST_MUL;
                    if (e_reg[0]) begin
                        mul_y_next = acc_reg;
                        kind_next  = MK_POW_ACC;
                    end else begin
                        mul_y_next = sq_reg;
                        kind_next  = MK_POW_SQ;
                    end
                end
            end
            ST_MUL: begin
                if (mul_y_reg == '0) begin
                    case (kind_reg)
                        MK_POW_ACC: begin
                            acc_next    = mul_acc_reg;
                            e_next[0]   = 1'b0;
                            state_next  = ST_POW;
                        end
                        MK_POW_SQ: begin
                            sq_next    = mul_acc_reg;
                            e_next     = e_reg >> 1;
                            state_next = ST_POW;
                        end
                        MK_LOOP: begin
                            acc_next = mul_acc_reg;
                            if (mul_acc_reg == NUM_WIDTH'(1)) begin
                                pend_prime_next = 1'b0;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_LOOP;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end else begin
                    mul_acc_next = acc_step;
                    mul_dbl_next = dbl_step;
                    mul_y_next   = mul_y_reg >> 1;
                end
            end
            ST_TEST: begin
                if (acc_reg == NUM_WIDTH'(1)) begin
                    pend_prime_next = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (cnt_reg == '0) begin
                    pend_prime_next = 1'b0;
                    state_next      = ST_DONE;
                end else if (acc_reg == n_minus_1) begin
                    pend_prime_next = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    mul_acc_next = '0;
                    mul_dbl_next = acc_reg;
                    mul_y_next   = acc_reg;
                    kind_next    = MK_LOOP;
                    cnt_next     = cnt_reg - CNT_W'(1);
                    state_next   = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_prime_next = pend_prime_reg;
                    out_bad_next   = pend_bad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kind_reg      <= MK_POW_ACC;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        a_reg          <= a_next;
        e_reg          <= e_next;
        acc_reg        <= acc_next;
        sq_reg         <= sq_next;
        mul_acc_reg    <= mul_acc_next;
        mul_dbl_reg    <= mul_dbl_next;
        mul_y_reg      <= mul_y_next;
        cnt_reg        <= cnt_next;
        pend_prime_reg <= pend_prime_next;
        pend_bad_reg   <= pend_bad_next;
        out_prime_reg  <= out_prime_next;
        out_bad_reg    <= out_bad_next;
    end

endmodule

`default_nettype wire

// ===== design/mrwt_checker.sv =====
// ============================================================================
// Miller-Rabin witness test checker
// Port-level assertions for the witness test unit, bound to the top level.
// ============================================================================
`default_nettype none

module mrwt_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [mrwt_pkg::TDATA_OUT_W-1:0] m_tdata,
    input wire logic                             m_tuser
);
    import mrwt_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("Stalled output word changed or was dropped.");

    a_bad_not_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[0] == 1'b0))
        else $error("Bad-input word reports a passing verdict.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Input taken again right after a word was accepted.");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_OUT_W-1:1] == '0))
        else $error("Output word padding is not zero.");

endmodule

bind miller_rabin_witness_test_unit mrwt_checker u_mrwt_checker (.*);

`default_nettype wire
